// File: hw/rtl/crlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_pkg: shared constants and types
// Line depth, control characters, opcodes and the controller/datapath links.
// ----------------------------------------------------------------------------
package crlf_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int IDX_W      = $clog2(LINE_DEPTH);

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic OP_RX    = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic take_byte;   // process one received byte
        logic start;       // issue read of the first stored byte
        logic advance;     // issue read of the next stored byte
        logic clear;       // drop line state
    } crlf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic complete;    // CR LF seen
        logic empty;       // no stored bytes
        logic last;        // word on output is the final one
    } crlf_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/crlf_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_rx_if: input channel
// Valid/ready channel carrying an opcode and a received byte.
// ----------------------------------------------------------------------------
interface crlf_rx_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/crlf_tx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_tx_if: output channel
// Valid/ready channel carrying a replayed byte and its end-of-line mark.
// ----------------------------------------------------------------------------
interface crlf_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_of_line;

    modport source (output valid, output tx_byte, output last_of_line, input ready);
    modport sink   (input valid, input tx_byte, input last_of_line, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/crlf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module crlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/crlf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_datapath: line store and line state
// Holds the byte count, CR and complete flags, the line RAM and read pointer.
// ----------------------------------------------------------------------------
module crlf_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire crlf_pkg::crlf_cmd_t  cmd,
    input  wire logic [7:0]           rx_byte,
    output crlf_pkg::crlf_stat_t      stat,
    output logic [7:0]                tx_byte,
    output logic                      last_of_line
);

    logic [crlf_pkg::IDX_W-1:0] count_reg, count_next;
    logic                       cr_reg, cr_next;
    logic                       complete_reg, complete_next;
    logic [crlf_pkg::IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic                       last_reg, last_next;
    logic                       wr_en;
    logic                       rd_en;

    always_comb
    begin
        count_next    = count_reg;
        cr_next       = cr_reg;
        complete_next = complete_reg;
        wr_en         = 1'b0;
        if (cmd.clear)
        begin
            count_next    = '0;
            cr_next       = 1'b0;
            complete_next = 1'b0;
        end
        else if (cmd.take_byte && !complete_reg)
        begin
            if (cr_reg)
            begin
                if (rx_byte == crlf_pkg::CHAR_LF)
                begin
                    complete_next = 1'b1;
                end
                else
                begin
                    // anything but LF after CR: drop the line
                    count_next = '0;
                    cr_next    = 1'b0;
                end
            end
            else if (rx_byte == crlf_pkg::CHAR_CR)
            begin
                cr_next = 1'b1;
            end
            else
            begin
                wr_en = 1'b1;
                // buffer full: drop the line
                if (count_reg == crlf_pkg::IDX_W'(crlf_pkg::LINE_DEPTH - 1))
                begin
                    count_next = '0;
                end
                else
                begin
                    count_next = count_reg + crlf_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        rd_en       = cmd.start || cmd.advance;
        rd_idx_next = rd_idx_reg;
        if (cmd.start)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.advance)
        begin
            rd_idx_next = rd_idx_reg + crlf_pkg::IDX_W'(1);
        end
        last_next = last_reg;
        if (rd_en)
        begin
            last_next = (rd_idx_next == count_reg - crlf_pkg::IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cr_reg       <= 1'b0;
            complete_reg <= 1'b0;
            rd_idx_reg   <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            cr_reg       <= cr_next;
            complete_reg <= complete_next;
            rd_idx_reg   <= rd_idx_next;
            last_reg     <= last_next;
        end
    end

    crlf_ram #(
        .WIDTH (8),
        .DEPTH (crlf_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (rd_idx_next),
        .rdata (tx_byte)
    );

    assign last_of_line  = last_reg;
    assign stat.complete = complete_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.last     = last_reg;

endmodule
`default_nettype wire

// File: hw/rtl/crlf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_ctrl: receive/replay controller
// Takes input words while idle and steps the datapath through a line replay.
// ----------------------------------------------------------------------------
module crlf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rx_valid,
    input  wire logic                 rx_op,
    input  wire logic                 tx_ready,
    input  wire crlf_pkg::crlf_stat_t stat,
    output crlf_pkg::crlf_cmd_t       cmd,
    output logic                      rx_ready,
    output logic                      tx_valid
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   rx_ready_reg, rx_ready_next;
    logic   tx_valid_reg, tx_valid_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        rx_ready_next = rx_ready_reg;
        tx_valid_next = tx_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid && rx_ready_reg)
                begin
                    if (rx_op == crlf_pkg::OP_RX)
                    begin
                        cmd.take_byte = 1'b1;
                    end
                    else if (stat.complete && !stat.empty)
                    begin
                        cmd.start     = 1'b1;
                        state_next    = ST_SEND;
                        rx_ready_next = 1'b0;
                        tx_valid_next = 1'b1;
                    end
                    else if (stat.complete)
                    begin
                        // empty line: nothing to send, just clear
                        cmd.clear = 1'b1;
                    end
                end
            end
            ST_SEND:
            begin
                if (tx_ready)
                begin
                    if (stat.last)
                    begin
                        cmd.clear     = 1'b1;
                        state_next    = ST_IDLE;
                        rx_ready_next = 1'b1;
                        tx_valid_next = 1'b0;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                rx_ready_next = 1'b1;
                tx_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rx_ready_reg <= 1'b1;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rx_ready_reg <= rx_ready_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    assign rx_ready = rx_ready_reg;
    assign tx_valid = tx_valid_reg;

endmodule
`default_nettype wire

// File: hw/rtl/crlf_line_receiver_echo_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crlf_line_receiver_echo_unit: CR LF line receiver with replay
// Collects received bytes into a line buffer and sends a finished line back.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries words of (op, rx_byte). With op = receive, the byte joins the
//   current line in the same cycle; while idle, rx takes one word per cycle.
//   A CR followed by LF closes the line. Any other byte after CR, or a line
//   that fills the buffer, drops the line. Bytes are ignored while a closed
//   line waits. With op = drain and a closed line, the stored bytes go out on
//   tx in received order, last_of_line set on the final one, then the line
//   state clears. Drain of an unclosed line does nothing.
//   Replay: the first byte appears on tx in the cycle after the drain word is
//   taken; following bytes come one per cycle, set by the single RAM read
//   port, while tx is ready. rx is held for the whole replay, and rx_ready
//   returns the cycle after the last byte is taken.
//   A stalled tx holds the current byte and last mark steady (the RAM read
//   register is not re-enabled) and stalls the replay.
//   Reset: counters and flags clear at once; the line RAM is not cleared,
//   since only bytes written to the current line are ever read. rx is ready
//   right out of reset.
// ----------------------------------------------------------------------------
module crlf_line_receiver_echo_unit (
    input wire logic   clk,
    input wire logic   rst_n,
    crlf_rx_if.sink    rx,
    crlf_tx_if.source  tx
);

    crlf_pkg::crlf_cmd_t  cmd;
    crlf_pkg::crlf_stat_t stat;

    // sequencing: accept, start replay, step per taken word, clear at end
    crlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_op    (rx.op),
        .tx_ready (tx.ready),
        .stat     (stat),
        .cmd      (cmd),
        .rx_ready (rx.ready),
        .tx_valid (tx.valid)
    );

    // line state, line RAM, read pointer and output payload
    crlf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rx_byte      (rx.rx_byte),
        .stat         (stat),
        .tx_byte      (tx.tx_byte),
        .last_of_line (tx.last_of_line)
    );

endmodule
`default_nettype wire

// File: bench/crlf_echo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlf_echo_checker: line replay predictor and scoreboard
// Watches the rx and tx channels, tracks the line state from every accepted
// rx word, queues the replay words a drain should produce and compares each
// accepted tx word against the oldest one.
// ----------------------------------------------------------------------------
module crlf_echo_checker
    import crlf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    crlf_rx_if   rx,
    crlf_tx_if   tx,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } echo_word_t;

    logic [7:0]       line_mem [LINE_DEPTH];
    logic [IDX_W-1:0] line_len    = '0;
    logic             cr_armed    = 1'b0;
    logic             line_closed = 1'b0;
    echo_word_t       echo_q [$];
    int               fail_total  = 0;

    initial begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] replay mismatch: %s", $time, what);
        fail_total++;
    endtask

    task automatic drop_line();
        line_len    = '0;
        cr_armed    = 1'b0;
        line_closed = 1'b0;
    endtask

    // Advance the line state by one accepted rx word.
    task automatic absorb_word(input logic op, input logic [7:0] b);
        int n;
        int i;
        if (op == OP_DRAIN) begin
            if (line_closed) begin
                n = int'(line_len);
                for (i = 0; i < n; i++)
                    echo_q.push_back('{line_mem[i], (i == n - 1)});
                drop_line();
            end
        end else if (!line_closed) begin
            if (cr_armed) begin
                if (b == CHAR_LF)
                    line_closed = 1'b1;
                else
                    drop_line();
            end else if (b == CHAR_CR) begin
                cr_armed = 1'b1;
            end else begin
                line_mem[line_len] = b;
                // a full buffer drops the line
                line_len = (line_len == IDX_W'(LINE_DEPTH - 1)) ? '0 : line_len + 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        echo_word_t seen;
        echo_word_t want;
        if (!rst_n) begin
            drop_line();
            echo_q.delete();
        end else begin
            // tx first: a drain taken at this edge cannot have output yet
            if (tx.valid && tx.ready) begin
                seen = '{tx.tx_byte, tx.last_of_line};
                if (echo_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %02h last=%0b",
                                              seen.data, seen.last));
                end else begin
                    want = echo_q.pop_front();
                    if (seen.data !== want.data)
                        report_mismatch($sformatf("tx_byte %02h, want %02h",
                                                  seen.data, want.data));
                    if (seen.last !== want.last)
                        report_mismatch($sformatf("last_of_line %0b, want %0b on byte %02h",
                                                  seen.last, want.last, want.data));
                end
            end
            if (rx.valid && rx.ready)
                absorb_word(rx.op, rx.rx_byte);
        end
        errors  <= fail_total;
        pending <= echo_q.size();
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for crlf_line_receiver_echo_unit
// Drives rx words in random bursts: a short directed opening, then mostly
// well-formed CR LF lines with random content, broken endings and noise.
// tx stalls on its own pattern, with one long hold-off that backs up rx.
// The checker beside the block predicts and compares every replayed word.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_WORDS  = 450;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;

    // how a generated line ends
    typedef enum int {
        TERM_CRLF,      // proper CR LF, line closes
        TERM_CR_JUNK,   // CR then some other byte, line drops
        TERM_CR_CR,     // CR twice, line drops
        TERM_OPEN       // no ending, next line's bytes join this one
    } line_term_t;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    bit   hold_tx = 1'b0;   // raised by stimulus, cleared by the tx process
    int   err_count;
    int   open_count;
    int   burst_left = 0;
    int   words_sent = 0;

    crlf_rx_if rx_ch ();
    crlf_tx_if tx_ch ();

    crlf_line_receiver_echo_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch)
    );

    crlf_echo_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .tx      (tx_ch),
        .errors  (err_count),
        .pending (open_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin : run_limit
        #4_000_000;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: offer one word and hold it until taken. Bursts of random length
    // are separated by random gaps; a quarter of the gaps are zero, so some
    // stretches run back to back. The gap is taken before the word, so valid
    // is never dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic offer_word(input logic op, input logic [7:0] b, input bit counted);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.op      <= op;
        rx_ch.rx_byte <= b;
        // hold until the block takes the word
        do @(posedge clk); while (!rx_ch.ready);
        if (counted)
            words_sent++;
    endtask

    // Random line content: anything but CR, LF included as plain data.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == crlf_pkg::CHAR_CR) ? (b ^ 8'h80) : b;
    endfunction

    task automatic send_drain();
        // rx_byte is a don't-care on a drain; randomize it anyway
        offer_word(crlf_pkg::OP_DRAIN, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_line(input int len, input line_term_t term);
        logic [7:0] junk;
        for (int i = 0; i < len; i++)
            offer_word(crlf_pkg::OP_RX, text_byte(), 1'b1);
        case (term)
            TERM_CRLF: begin
                offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
                offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_LF, 1'b1);
            end
            TERM_CR_JUNK: begin
                junk = text_byte();
                if (junk == crlf_pkg::CHAR_LF)
                    junk = ~junk;
                offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
                offer_word(crlf_pkg::OP_RX, junk, 1'b1);
            end
            TERM_CR_CR: begin
                offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
                offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver: tx ready follows a pattern that changes from one random-length
    // phase to the next - always ready, three-quarters ready, coin flip, or
    // mostly stalled. On request, hold ready low for a long stretch so the
    // replay backs up and rx stops taking words.
    // ------------------------------------------------------------------------
    initial begin : tx_ready_gen
        int unsigned phase_left;
        int unsigned mode;
        int unsigned tick;
        phase_left  = 0;
        mode        = 0;
        tick        = 0;
        tx_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_tx) begin
                tx_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_tx = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(0, 3);
                    phase_left = $urandom_range(32, 200);
                end
                phase_left--;
                tick++;
                case (mode)
                    0:       tx_ch.ready <= 1'b1;
                    1:       tx_ch.ready <= ((tick % 4) != 3);
                    2:       tx_ch.ready <= 1'($urandom_range(0, 1));
                    default: tx_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int         len;
        int         pick;
        int         n_lines;
        int         wait_cycles;
        line_term_t term;

        rx_ch.valid   = 1'b0;
        rx_ch.op      = crlf_pkg::OP_RX;
        rx_ch.rx_byte = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed opening ---
        // drain with no closed line: nothing comes out, nothing changes
        offer_word(crlf_pkg::OP_DRAIN, 8'h00, 1'b1);
        // byte extremes plus a bare LF, which is plain data without a CR
        offer_word(crlf_pkg::OP_RX, 8'h00, 1'b1);
        offer_word(crlf_pkg::OP_RX, 8'hff, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_LF, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_LF, 1'b1);
        offer_word(crlf_pkg::OP_DRAIN, 8'hff, 1'b1);
        // bytes after the line closes are dropped, CR included
        offer_word(crlf_pkg::OP_RX, 8'h41, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_LF, 1'b1);
        offer_word(crlf_pkg::OP_RX, 8'h42, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        offer_word(crlf_pkg::OP_DRAIN, 8'h5a, 1'b1);
        // empty closed line: drain gives nothing but clears; second drain idles
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_LF, 1'b1);
        offer_word(crlf_pkg::OP_DRAIN, 8'h00, 1'b1);
        offer_word(crlf_pkg::OP_DRAIN, 8'h00, 1'b1);
        // CR then a non-LF byte drops the line, as does CR CR
        offer_word(crlf_pkg::OP_RX, 8'h31, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        offer_word(crlf_pkg::OP_RX, 8'h32, 1'b1);
        offer_word(crlf_pkg::OP_RX, 8'h33, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
        send_line(1, TERM_CRLF);
        send_drain();

        // --- random lines ---
        // The first four lines sit at the buffer limit: one short of the
        // longest fitting line, that line, one that overflows, one past it.
        words_sent = 0;
        n_lines    = 0;
        while (words_sent < RANDOM_WORDS) begin
            if (n_lines < 4) begin
                len = crlf_pkg::LINE_DEPTH - 2 + n_lines;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(0, 8);
                else if (pick < 92)
                    len = $urandom_range(9, 30);
                else
                    len = $urandom_range(crlf_pkg::LINE_DEPTH - 9,
                                         crlf_pkg::LINE_DEPTH + 6);
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)
                term = TERM_CRLF;
            else if (pick < 88)
                term = TERM_CR_JUNK;
            else if (pick < 94)
                term = TERM_CR_CR;
            else
                term = TERM_OPEN;

            // Long tx hold-off over a sizable line: the replay stalls and rx
            // backs up while the sender keeps offering words. Drain any closed
            // line first, then CR and a plain byte leave an empty line or one
            // holding that byte, so the line below always replays.
            if (n_lines == 12) begin
                send_drain();
                offer_word(crlf_pkg::OP_RX, crlf_pkg::CHAR_CR, 1'b1);
                offer_word(crlf_pkg::OP_RX, 8'h41, 1'b1);
                hold_tx <= 1'b1;
                len     = 40;
                term    = TERM_CRLF;
            end

            send_line(len, term);
            // noise while a line waits; the block ignores it
            if (term == TERM_CRLF && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    offer_word(crlf_pkg::OP_RX, 8'($urandom_range(0, 255)), 1'b0);
            if (n_lines == 12 || $urandom_range(0, 9) != 0)
                send_drain();
            // stray word of either kind
            if ($urandom_range(0, 7) == 0)
                offer_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
            n_lines++;
        end

        // --- wind down ---
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (open_count != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0 && open_count == 0) begin
            $display("tb_top passed");
        end else begin
            if (open_count != 0)
                $display("%0d replay words never arrived", open_count);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: crlf_line_receiver_echo_unit.f
hw/rtl/crlf_pkg.sv
hw/rtl/crlf_rx_if.sv
hw/rtl/crlf_tx_if.sv
hw/rtl/crlf_ram.sv
hw/rtl/crlf_datapath.sv
hw/rtl/crlf_ctrl.sv
hw/rtl/crlf_line_receiver_echo_unit.sv
bench/crlf_echo_checker.sv
bench/tb_top.sv
